[rtl/ttip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttip_pkg;

  localparam int RESULT_BITS_DEFAULT = 32;
  localparam int VALUE_W = 32;
  localparam int BASE_W = 6;
  localparam int DIGIT_W = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UB    = 8'h42;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LB    = 8'h62;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // One character after classification, as it travels through the queue.
  typedef struct packed {
    logic               has_char;
    logic               last;
    logic               is_space;
    logic               is_minus;
    logic               is_zero;
    logic               is_b;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  function automatic logic [DIGIT_W-1:0] digit_of(logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = DIGIT_W'(c - CHAR_ZERO);
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      d = DIGIT_W'(c - CHAR_LA) + DIGIT_TEN;
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      d = DIGIT_W'(c - CHAR_UA) + DIGIT_TEN;
    end
    return d;
  endfunction

  function automatic logic prefix_base(logic [BASE_W-1:0] b);
    return (b == BASE_AUTO) || (b == BASE_BIN) || (b == BASE_OCT) || (b == BASE_HEX);
  endfunction

endpackage

`default_nettype wire

[rtl/ttip_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttip_front (
  input  wire logic [7:0]     ch_i,
  input  wire logic           has_char_i,
  input  wire logic           last_i,
  output ttip_pkg::item_t     item_o
);

  always_comb begin
    item_o.has_char = has_char_i;
    item_o.last     = last_i;
    item_o.is_space = (ch_i == ttip_pkg::CHAR_SPACE);
    item_o.is_minus = (ch_i == ttip_pkg::CHAR_MINUS);
    item_o.is_zero  = (ch_i == ttip_pkg::CHAR_ZERO);
    item_o.is_b     = (ch_i == ttip_pkg::CHAR_LB) || (ch_i == ttip_pkg::CHAR_UB);
    item_o.is_x     = (ch_i == ttip_pkg::CHAR_LX) || (ch_i == ttip_pkg::CHAR_UX);
    item_o.digit    = ttip_pkg::digit_of(ch_i);
  end

endmodule

`default_nettype wire

[rtl/ttip_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttip_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ttip_pkg::item_t push_item_i,
  output logic                 not_full_o,
  input  wire logic            pop_i,
  output logic                 not_empty_o,
  output ttip_pkg::item_t      head_o
);

  ttip_pkg::item_t                 mem_q [ttip_pkg::QUEUE_DEPTH];
  logic [ttip_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ttip_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ttip_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            do_push, do_pop;

  assign not_full_o  = (count_q != ttip_pkg::QCNT_W'(ttip_pkg::QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ttip_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttip_back #(
  parameter int RESULT_BITS = ttip_pkg::RESULT_BITS_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ttip_pkg::BASE_W-1:0]   cfg_wdata_i,
  input  wire logic                          item_valid_i,
  input  wire ttip_pkg::item_t               item_i,
  output logic                               item_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [ttip_pkg::VALUE_W-1:0] value_o,
  output logic                               error_flag_o
);

  localparam int MAG_W  = RESULT_BITS - 1;
  localparam int PROD_W = RESULT_BITS + ttip_pkg::BASE_W;
  localparam int VAL_W  = (RESULT_BITS > ttip_pkg::VALUE_W) ? RESULT_BITS : ttip_pkg::VALUE_W;
  localparam logic [PROD_W-1:0] LIMIT_P = PROD_W'({MAG_W{1'b1}});
  localparam logic [VAL_W-1:0]  LIMIT_V = VAL_W'({MAG_W{1'b1}});

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_FIRST,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic                          neg_q, neg_d;
  logic [ttip_pkg::BASE_W-1:0]   abase_q, abase_d;
  logic [ttip_pkg::BASE_W-1:0]   base_q, base_d;
  logic [MAG_W-1:0]              mag_q, mag_d;
  logic                          err_q, err_d;
  logic                          ovf_q, ovf_d;
  logic                          stop_q, stop_d;
  logic                          out_valid_q, out_valid_d;
  logic [ttip_pkg::VALUE_W-1:0]  value_q, value_d;
  logic                          error_q, error_d;

  logic                          do_digit;
  logic [ttip_pkg::BASE_W-1:0]   b_use;
  logic [PROD_W-1:0]             prod;
  logic [VAL_W-1:0]              mag_ext;
  logic [VAL_W-1:0]              val_full;
  logic                          pop;

  // A string end needs a free output slot; other characters never wait on the output side.
  assign pop        = item_valid_i && (!item_i.last || !out_valid_q || out_ready_i);
  assign item_pop_o = pop;

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    abase_d     = abase_q;
    mag_d       = mag_q;
    err_d       = err_q;
    ovf_d       = ovf_q;
    stop_d      = stop_q;
    base_d      = cfg_we_i ? cfg_wdata_i : base_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    error_d     = error_q;
    do_digit    = 1'b0;
    b_use       = abase_q;
    prod        = '0;
    mag_ext     = '0;
    val_full    = '0;

    if (pop) begin
      if (item_i.has_char && !stop_q) begin
        case (phase_q)
          PH_SKIP, PH_FIRST: begin
            if (phase_q == PH_SKIP && item_i.is_space) begin
              phase_d = PH_SKIP;
            end else if (phase_q == PH_SKIP && item_i.is_minus) begin
              neg_d   = 1'b1;
              phase_d = PH_FIRST;
            end else if (item_i.is_zero && ttip_pkg::prefix_base(base_q)) begin
              abase_d = base_q;
              phase_d = PH_ZERO;
            end else begin
              abase_d  = (base_q == ttip_pkg::BASE_AUTO) ? ttip_pkg::BASE_DEC : base_q;
              b_use    = abase_d;
              do_digit = 1'b1;
              phase_d  = PH_DIGITS;
            end
          end
          PH_ZERO: begin
            phase_d = PH_DIGITS;
            if (item_i.is_b &&
                (abase_q == ttip_pkg::BASE_AUTO || abase_q == ttip_pkg::BASE_BIN)) begin
              abase_d = ttip_pkg::BASE_BIN;
            end else if (item_i.is_x &&
                         (abase_q == ttip_pkg::BASE_AUTO || abase_q == ttip_pkg::BASE_HEX)) begin
              abase_d = ttip_pkg::BASE_HEX;
            end else if (abase_q == ttip_pkg::BASE_AUTO || abase_q == ttip_pkg::BASE_OCT) begin
              abase_d  = ttip_pkg::BASE_OCT;
              b_use    = ttip_pkg::BASE_OCT;
              do_digit = 1'b1;
            end else begin
              // The held zero is a plain digit here and leaves the magnitude at zero.
              b_use    = abase_q;
              do_digit = 1'b1;
            end
          end
          PH_DIGITS: begin
            b_use    = abase_q;
            do_digit = 1'b1;
          end
          default: begin
            phase_d = PH_SKIP;
          end
        endcase
      end

      if (do_digit) begin
        prod  = PROD_W'(mag_q) * PROD_W'(b_use) + PROD_W'(item_i.digit);
        err_d = 1'b0;
        if (b_use < ttip_pkg::BASE_BIN || b_use > ttip_pkg::BASE_MAX ||
            item_i.digit >= b_use) begin
          err_d  = 1'b1;
          stop_d = 1'b1;
        end else if (prod > LIMIT_P) begin
          ovf_d  = 1'b1;
          err_d  = 1'b1;
          stop_d = 1'b1;
        end else begin
          mag_d = prod[MAG_W-1:0];
        end
      end

      if (item_i.last) begin
        mag_ext  = VAL_W'(mag_d);
        val_full = ovf_d ? LIMIT_V : (neg_d ? (~mag_ext + 1'b1) : mag_ext);
        value_d  = val_full[ttip_pkg::VALUE_W-1:0];
        // A lone leading zero at the end of the string is the digit zero.
        error_d  = (phase_d == PH_ZERO && !stop_d) ? 1'b0 : err_d;
        out_valid_d = 1'b1;
        phase_d  = PH_SKIP;
        neg_d    = 1'b0;
        abase_d  = '0;
        mag_d    = '0;
        err_d    = 1'b1;
        ovf_d    = 1'b0;
        stop_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      abase_q     <= '0;
      base_q      <= '0;
      mag_q       <= '0;
      err_q       <= 1'b1;
      ovf_q       <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      error_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      abase_q     <= abase_d;
      base_q      <= base_d;
      mag_q       <= mag_d;
      err_q       <= err_d;
      ovf_q       <= ovf_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      value_q     <= value_d;
      error_q     <= error_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = $signed(value_q);
  assign error_flag_o = error_q;

endmodule

`default_nettype wire

[rtl/text_to_integer_parser.sv]
// Path: a string end accepted into the queue is popped from its head by the back end,
// which registers the result and holds out_valid_o until out_ready_i takes it.
// Throughput: one character per cycle unless a string end waits on a stalled result; the back end
// does one multiply-add and limit compare per character, decoupled by a two-entry queue.
// Reset: rst_ni is asynchronous and active low; it empties the queue and output stage,
// returns the parser to skipping spaces and sets the base register to 0.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_parser #(
  parameter int RESULT_BITS = ttip_pkg::RESULT_BITS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ttip_pkg::BASE_W-1:0]     cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      ch_i,
  input  wire logic                            has_char_i,
  input  wire logic                            last_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [ttip_pkg::VALUE_W-1:0]  value_o,
  output logic                                 error_flag_o
);

  ttip_pkg::item_t front_item;
  ttip_pkg::item_t head_item;
  logic            q_valid;
  logic            q_pop;

  ttip_front u_front (
    .ch_i       (ch_i),
    .has_char_i (has_char_i),
    .last_i     (last_i),
    .item_o     (front_item)
  );

  ttip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .not_full_o  (in_ready_o),
    .pop_i       (q_pop),
    .not_empty_o (q_valid),
    .head_o      (head_item)
  );

  ttip_back #(
    .RESULT_BITS (RESULT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (q_valid),
    .item_i       (head_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .error_flag_o (error_flag_o)
  );

  // A full queue must have something for the back end to take.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue reports full while empty");

  // Every accepted request is waiting in the queue on the next cycle.
  a_accept_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> q_valid)
    else $error("accepted request missing from queue");

  // The back end never takes a string end while a waiting result is stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && q_pop |-> !head_item.last)
    else $error("result overwritten before it was taken");

  a_reset_out_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

[tb/sv/ttip_result_checker.sv]
`timescale 1ns / 1ps

module ttip_result_checker #(
  parameter int RESULT_BITS = ttip_pkg::RESULT_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttip_pkg::BASE_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [7:0]                          ch_i,
  input  logic                                has_char_i,
  input  logic                                last_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [ttip_pkg::VALUE_W-1:0] value_i,
  input  logic                                error_flag_i,
  output int                                  mismatch_count_o,
  output int                                  numbers_owed_o
);
  import ttip_pkg::*;

  typedef enum logic [1:0] {
    SCAN_SPACES,
    SCAN_AFTER_SIGN,
    SCAN_LEAD_ZERO,
    SCAN_DIGITS
  } scan_phase_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      error_flag;
  } parsed_number_t;

  localparam logic [63:0] POS_LIMIT = (64'd1 << (RESULT_BITS - 1)) - 64'd1;

  logic [BASE_W-1:0] base_reg;
  logic [BASE_W-1:0] run_base;
  scan_phase_e       phase;
  logic              negative;
  logic              err_seen;
  logic              overflowed;
  logic              halted;
  logic [63:0]       magnitude;
  parsed_number_t    pending_numbers[$];
  parsed_number_t    want;
  int                failures;

  function automatic logic [DIGIT_W-1:0] char_digit(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return DIGIT_W'(c - CHAR_ZERO);
    if (c >= CHAR_LA && c <= CHAR_LZ) return DIGIT_W'(c - CHAR_LA + 8'd10);
    if (c >= CHAR_UA && c <= CHAR_UZ) return DIGIT_W'(c - CHAR_UA + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic void clear_scan();
    phase = SCAN_SPACES;
    negative = 1'b0;
    run_base = BASE_AUTO;
    magnitude = '0;
    err_seen = 1'b1;
    overflowed = 1'b0;
    halted = 1'b0;
  endfunction

  function automatic void accumulate(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = char_digit(c);
    if (halted) return;
    err_seen = 1'b0;
    if (run_base < BASE_BIN || run_base > BASE_MAX || d >= run_base) begin
      err_seen = 1'b1;
      halted = 1'b1;
      return;
    end
    // Stop before the magnitude passes the positive limit.
    if (magnitude > (POS_LIMIT - 64'(d)) / 64'(run_base)) begin
      overflowed = 1'b1;
      err_seen = 1'b1;
      halted = 1'b1;
      return;
    end
    magnitude = magnitude * 64'(run_base) + 64'(d);
  endfunction

  // The base register is latched here, at the first character past spaces and sign.
  function automatic void start_digits(input logic [7:0] c);
    run_base = base_reg;
    if (c == CHAR_ZERO && (run_base == BASE_AUTO || run_base == BASE_BIN ||
                           run_base == BASE_OCT || run_base == BASE_HEX)) begin
      phase = SCAN_LEAD_ZERO;
    end else begin
      if (run_base == BASE_AUTO) run_base = BASE_DEC;
      phase = SCAN_DIGITS;
      accumulate(c);
    end
  endfunction

  function automatic void resolve_zero(input logic [7:0] c);
    phase = SCAN_DIGITS;
    if ((c == CHAR_LB || c == CHAR_UB) && (run_base == BASE_AUTO || run_base == BASE_BIN)) begin
      run_base = BASE_BIN;
    end else if ((c == CHAR_LX || c == CHAR_UX) &&
                 (run_base == BASE_AUTO || run_base == BASE_HEX)) begin
      run_base = BASE_HEX;
    end else if (run_base == BASE_AUTO || run_base == BASE_OCT) begin
      run_base = BASE_OCT;
      accumulate(c);
    end else begin
      accumulate(CHAR_ZERO);
      accumulate(c);
    end
  endfunction

  function automatic void absorb_char(input logic [7:0] c, input logic carries,
                                      input logic ends);
    parsed_number_t num;
    logic [63:0]    signed_mag;
    if (carries && !halted) begin
      case (phase)
        SCAN_SPACES: begin
          if (c == CHAR_MINUS) begin
            negative = 1'b1;
            phase = SCAN_AFTER_SIGN;
          end else if (c != CHAR_SPACE) begin
            start_digits(c);
          end
        end
        SCAN_AFTER_SIGN: start_digits(c);
        SCAN_LEAD_ZERO:  resolve_zero(c);
        default:         accumulate(c);
      endcase
    end
    if (!ends) return;
    // A zero still waiting at the end of the string is simply the digit zero.
    if (phase == SCAN_LEAD_ZERO && !halted) begin
      if (run_base == BASE_AUTO) run_base = BASE_DEC;
      accumulate(CHAR_ZERO);
    end
    if (overflowed) signed_mag = POS_LIMIT;
    else signed_mag = negative ? 64'd0 - magnitude : magnitude;
    num.value = signed_mag[VALUE_W-1:0];
    num.error_flag = err_seen;
    pending_numbers.insert(pending_numbers.size(), num);
    clear_scan();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_reg = BASE_AUTO;
      clear_scan();
      pending_numbers.delete();
      failures = 0;
      mismatch_count_o <= 0;
      numbers_owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_numbers.size() == 0) begin
          $display("%0t: result with none expected: value %0d error_flag %0b",
                   $time, value_i, error_flag_i);
          failures++;
        end else begin
          want = pending_numbers.pop_front();
          if (value_i !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, want.value, value_i);
            failures++;
          end
          if (error_flag_i !== want.error_flag) begin
            $display("%0t: error_flag mismatch: expected %0b, actual %0b",
                     $time, want.error_flag, error_flag_i);
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_char(ch_i, has_char_i, last_i);
      if (cfg_we_i) base_reg = cfg_wdata_i;
      mismatch_count_o <= failures;
      numbers_owed_o <= pending_numbers.size();
    end
  end

endmodule

[tb/sv/text_to_integer_parser_tb.sv]
`timescale 1ns / 1ps

module text_to_integer_parser_tb;
  import ttip_pkg::*;

  localparam int          RANDOM_CHARS = 650;
  localparam int          LONG_HOLD = 200;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          PHASE_COUNT = 10;
  localparam logic [BASE_W-1:0] BASE_TOP = '1;
  localparam logic [BASE_W-1:0] BASE_UNARY = 6'd1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [BASE_W-1:0]         cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                ch = '0;
  logic                      has_char = 1'b0;
  logic                      last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic                      error_flag;
  int                        mismatches;
  int                        numbers_owed;

  bit                        no_gaps = 1'b0;
  bit                        hold_results = 1'b0;
  logic [BASE_W-1:0]         cur_base = BASE_AUTO;
  int                        chars_sent = 0;
  int                        cycles = 0;
  int                        stall_left = 0;

  always #1 clk = ~clk;

  text_to_integer_parser u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .ch_i         (ch),
    .has_char_i   (has_char),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .value_o      (value),
    .error_flag_o (error_flag)
  );

  ttip_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .ch_i             (ch),
    .has_char_i       (has_char),
    .last_i           (last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .value_i          (value),
    .error_flag_i     (error_flag),
    .mismatch_count_o (mismatches),
    .numbers_owed_o   (numbers_owed)
  );

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [7:0] digit_char(input logic [7:0] v);
    if (v < 8'd10) return CHAR_ZERO + v;
    return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + v - 8'd10;
  endfunction

  // Returns at the edge where the request is taken; valid stays up until the next call
  // decides whether to drop it.
  task automatic send_char(input logic [7:0] c, input logic carries, input logic ends);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    has_char <= carries;
    last <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (carries) chars_sent++;
  endtask

  task automatic send_text(input string s, input bit ends = 1'b1);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], 1'b1, ends && i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (numbers_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_base = b;
  endtask

  task automatic send_random_number();
    logic [7:0] text[$];
    string      prefix;
    int         roll;
    int         ndig;
    int         dbase;
    int         i;
    bit         end_empty;
    logic [7:0] dval;
    roll = $urandom_range(99);
    prefix = "";
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) text.insert(text.size(), 8'($urandom_range(255)));
    end else if (roll < 12) begin
      // Values right at the positive limit and one past it, some with a minus sign.
      if (cur_base == BASE_HEX) begin
        case ($urandom_range(2))
          0:       prefix = "7fffffff";
          1:       prefix = "80000000";
          default: prefix = "-7FFFFFFF";
        endcase
      end else begin
        case ($urandom_range(3))
          0:       prefix = "2147483647";
          1:       prefix = "2147483648";
          2:       prefix = "-2147483648";
          default: prefix = "-2147483647";
        endcase
      end
      for (i = 0; i < prefix.len(); i++) text.insert(text.size(), prefix[i]);
    end else begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) text.insert(text.size(), CHAR_SPACE);
      if ($urandom_range(3) == 0) text.insert(text.size(), CHAR_MINUS);
      dbase = cur_base;
      case (cur_base)
        BASE_AUTO: begin
          case ($urandom_range(3))
            0: begin
              prefix = $urandom_range(1) ? "0x" : "0X";
              dbase = 16;
            end
            1: begin
              prefix = $urandom_range(1) ? "0b" : "0B";
              dbase = 2;
            end
            2: begin
              prefix = "0";
              dbase = 8;
            end
            default: dbase = 10;
          endcase
        end
        BASE_BIN: if ($urandom_range(1)) prefix = $urandom_range(1) ? "0b" : "0B";
        BASE_HEX: if ($urandom_range(1)) prefix = $urandom_range(1) ? "0x" : "0X";
        BASE_OCT: if ($urandom_range(1)) prefix = "0";
        default:  if (cur_base < BASE_BIN || cur_base > BASE_MAX) dbase = 10;
      endcase
      for (i = 0; i < prefix.len(); i++) text.insert(text.size(), prefix[i]);
      if ($urandom_range(19) == 0) ndig = 0;
      else if ($urandom_range(4) == 0) ndig = $urandom_range(6, 12);
      else ndig = $urandom_range(1, 5);
      for (i = 0; i < ndig; i++) begin
        dval = 8'($urandom_range(dbase - 1));
        // Without a prefix a leading zero would switch detection to octal.
        if (i == 0 && cur_base == BASE_AUTO && dbase == 10 && dval == 8'd0) dval = 8'd1;
        text.insert(text.size(), digit_char(dval));
      end
      if (roll < 24 && text.size() > 0)
        text.insert($urandom_range(text.size() - 1), 8'($urandom_range(255)));
    end
    end_empty = (text.size() == 0) || ($urandom_range(9) == 0);
    for (i = 0; i < text.size(); i++) begin
      if ($urandom_range(29) == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
      send_char(text[i], 1'b1, !end_empty && i == text.size() - 1);
    end
    if (end_empty) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Result side: random stalls, plus one long hold-off on request from the stimulus.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (hold_results) begin
          stall_left = LONG_HOLD;
          hold_results = 1'b0;
        end else if (!no_gaps && $urandom_range(3) == 0) begin
          stall_left = idle_cycles();
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_to_integer_parser_tb failed");
    $finish;
  end

  initial begin
    logic [BASE_W-1:0] phase_base;
    int                phase_idx;
    int                target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("0");
    send_text("0x");
    send_text("-");
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    send_text(" 0b1");
    send_text("07");
    send_char(8'hFF, 1'b1, 1'b1);
    send_text("1z5");
    // The base is latched at the first digit, so this write only affects the next number.
    send_text("-7", 1'b0);
    write_base(BASE_BIN);
    send_text("9");
    write_base(BASE_MAX);
    send_text("zzzzzz");
    write_base(BASE_UNARY);
    send_text("0");

    for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      case (phase_idx)
        0:       phase_base = BASE_AUTO;
        1:       phase_base = BASE_DEC;
        2:       phase_base = BASE_BIN;
        3:       phase_base = BASE_OCT;
        4:       phase_base = BASE_HEX;
        5:       phase_base = BASE_MAX;
        6:       phase_base = BASE_TOP;
        7:       phase_base = BASE_UNARY;
        8:       phase_base = 6'($urandom_range(3, 35));
        default: phase_base = BASE_AUTO;
      endcase
      write_base(phase_base);
      no_gaps = (phase_idx == 1);
      // Hold the result side off long enough for the input side to back up.
      if (phase_idx == 4) hold_results = 1'b1;
      target = chars_sent + RANDOM_CHARS / PHASE_COUNT;
      while (chars_sent < target) send_random_number();
    end
    no_gaps = 1'b0;

    drain();
    if (mismatches == 0 && numbers_owed == 0) begin
      $display("text_to_integer_parser_tb passed");
    end else begin
      $display("text_to_integer_parser_tb failed");
    end
    $finish;
  end

endmodule

[text_to_integer_parser.f]
rtl/ttip_pkg.sv
rtl/ttip_front.sv
rtl/ttip_queue.sv
rtl/ttip_back.sv
rtl/text_to_integer_parser.sv
tb/sv/ttip_result_checker.sv
tb/sv/text_to_integer_parser_tb.sv
